>>> design/sdtq_pkg.sv
// shared types and constants for the sorted deadline timer queue
package sdtq_pkg;

   localparam int TIME_W   = 64;
   localparam int HANDLE_W = 16;
   localparam int SLEEP_W  = 32;
   localparam int KIND_W   = 3;

   localparam logic [SLEEP_W-1:0] RESET_POLL_CAP = 32'd20000000;

   // request operation codes
   localparam logic OP_SCHEDULE = 1'b0;
   localparam logic OP_TICK     = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIRED     = 3'd0,
      KIND_FIRED_NOW = 3'd1,
      KIND_ACCEPTED  = 3'd2,
      KIND_REJECTED  = 3'd3,
      KIND_SLEEP     = 3'd4
   } kind_type;

   typedef enum logic {
      S_IDLE,
      S_TICK
   } state_type;

   // row-wide command to every cell
   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctl_type;

endpackage

>>> design/sdtq_cell.sv
// one slot of the sorted timer row: holds a deadline and handle, shifts to either neighbor
module sdtq_cell #(
   parameter int HB = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sdtq_pkg::cell_ctl_type     ctl,
   input  logic [sdtq_pkg::TIME_W-1:0] key,
   input  logic [HB-1:0]              new_handle,
   input  logic                       left_keep,
   input  logic                       left_valid,
   input  logic [sdtq_pkg::TIME_W-1:0] left_deadline,
   input  logic [HB-1:0]              left_handle,
   input  logic                       right_valid,
   input  logic [sdtq_pkg::TIME_W-1:0] right_deadline,
   input  logic [HB-1:0]              right_handle,
   output logic                       keep,
   output logic                       valid,
   output logic [sdtq_pkg::TIME_W-1:0] deadline,
   output logic [HB-1:0]              handle
);
   import sdtq_pkg::*;

   logic              valid_ff, valid_in;
   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic [HB-1:0]     handle_ff, handle_in;

   // entry stays in place on insert when it is due no later than the key
   assign keep = valid_ff && (deadline_ff <= key);

   // next slot contents
   always_comb begin
      valid_in    = valid_ff;
      deadline_in = deadline_ff;
      handle_in   = handle_ff;
      if (ctl.pop) begin
         valid_in    = right_valid;
         deadline_in = right_deadline;
         handle_in   = right_handle;
      end else if (ctl.insert && !keep) begin
         if (left_keep) begin
            valid_in    = 1'b1;
            deadline_in = key;
            handle_in   = new_handle;
         end else begin
            valid_in    = left_valid;
            deadline_in = left_deadline;
            handle_in   = left_handle;
         end
      end
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      handle_ff   <= handle_in;
   end

   assign valid    = valid_ff;
   assign deadline = deadline_ff;
   assign handle   = handle_ff;

endmodule

>>> design/sorted_deadline_timer_queue.sv
// top level: request/response control around the row of sorted timer cells
//
// Timers sit in a row of CAPACITY cells kept in deadline order, earliest at
// the head; equal deadlines keep arrival order. A schedule request fires at
// once if its deadline is not after current_time, is rejected when every
// cell is occupied, and otherwise every cell compares the new deadline in
// parallel and the later entries move one cell down. In a tick request the
// head cell is checked each cycle, one expired entry is shifted out of the
// row per cycle while rsp_tready takes the responses, and the sleep interval
// (time to the new head, at most the poll cap: RESET_POLL_CAP after reset,
// else csr_wr_data's last written value) closes the tick with tlast. Each
// response cycle waits for rsp_tready; a new request is taken only while the
// response register is empty or being read in the same cycle, so a response
// held back by rsp_tready also holds off req_tready. No clearing pass is needed
// after reset. Handles are kept to their low HANDLE_BITS bits, at most HANDLE_W.
module sorted_deadline_timer_queue #(
   parameter int CAPACITY    = 16,
   parameter int HANDLE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request: tdata = deadline[63:0], handle[79:64], current_time[143:80]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,
   // request: tuser = operation[0]
   input  logic [0:0]   req_tuser,
   // response: tdata = fired_handle[15:0], sleep_interval[47:16]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,
   // response: tuser = kind[2:0]
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast,
   // poll cap register
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);
   import sdtq_pkg::*;

   localparam int HB = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

   // request fields
   logic [TIME_W-1:0] req_deadline, req_current_time;
   logic [HB-1:0]     req_handle;
   logic              req_operation;

   assign req_deadline     = req_tdata[63:0];
   assign req_handle       = req_tdata[64 +: HB];
   assign req_current_time = req_tdata[143:80];
   assign req_operation    = req_tuser[0];

   // state
   state_type         state_ff, state_in;
   logic [TIME_W-1:0] now_ff;
   logic [SLEEP_W-1:0] poll_cap_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [SLEEP_W-1:0] rsp_sleep_ff, rsp_sleep_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_load;

   // cell row
   cell_ctl_type      ctl;
   logic [TIME_W-1:0] key;
   logic [CAPACITY-1:0] cell_valid, cell_keep;
   logic [TIME_W-1:0] cell_deadline [CAPACITY];
   logic [HB-1:0]     cell_handle [CAPACITY];

   logic              out_free, req_accept, due_now, row_full, head_due;
   logic [TIME_W-1:0] remain;
   logic [SLEEP_W-1:0] sleep_value;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign due_now    = req_deadline <= req_current_time;
   assign row_full   = cell_valid[CAPACITY-1];
   assign head_due   = cell_keep[0];
   assign key        = (state_ff == S_TICK) ? now_ff : req_deadline;

   // sleep interval from the head cell, capped
   assign remain = cell_deadline[0] - now_ff;
   always_comb begin
      sleep_value = poll_cap_ff;
      if (cell_valid[0] && (remain < TIME_W'(poll_cap_ff))) begin
         sleep_value = remain[SLEEP_W-1:0];
      end
   end

   // cell instances
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic              l_keep, l_valid, r_valid;
      logic [TIME_W-1:0] l_deadline, r_deadline;
      logic [HB-1:0]     l_handle, r_handle;

      if (i == 0) begin : g_head
         assign l_keep     = 1'b1;
         assign l_valid    = 1'b0;
         assign l_deadline = '0;
         assign l_handle   = '0;
      end else begin : g_body
         assign l_keep     = cell_keep[i-1];
         assign l_valid    = cell_valid[i-1];
         assign l_deadline = cell_deadline[i-1];
         assign l_handle   = cell_handle[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign r_valid    = 1'b0;
         assign r_deadline = '0;
         assign r_handle   = '0;
      end else begin : g_inner
         assign r_valid    = cell_valid[i+1];
         assign r_deadline = cell_deadline[i+1];
         assign r_handle   = cell_handle[i+1];
      end

      sdtq_cell #(.HB(HB)) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctl            (ctl),
         .key            (key),
         .new_handle     (req_handle),
         .left_keep      (l_keep),
         .left_valid     (l_valid),
         .left_deadline  (l_deadline),
         .left_handle    (l_handle),
         .right_valid    (r_valid),
         .right_deadline (r_deadline),
         .right_handle   (r_handle),
         .keep           (cell_keep[i]),
         .valid          (cell_valid[i]),
         .deadline       (cell_deadline[i]),
         .handle         (cell_handle[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_operation == OP_TICK) begin
               state_in = S_TICK;
            end
         end
         S_TICK: begin
            if (out_free && !head_due) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // handshake, cell commands and response contents
   always_comb begin
      req_tready    = 1'b0;
      ctl           = '0;
      out_load      = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_sleep_in  = rsp_sleep_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = out_free;
            if (req_accept && req_operation == OP_SCHEDULE) begin
               out_load      = 1'b1;
               rsp_handle_in = '0;
               rsp_sleep_in  = '0;
               rsp_last_in   = 1'b1;
               if (due_now) begin
                  rsp_kind_in   = KIND_FIRED_NOW;
                  rsp_handle_in = HANDLE_W'(req_handle);
               end else if (row_full) begin
                  rsp_kind_in = KIND_REJECTED;
               end else begin
                  rsp_kind_in = KIND_ACCEPTED;
                  ctl.insert  = 1'b1;
               end
            end
         end
         S_TICK: begin
            if (out_free) begin
               out_load = 1'b1;
               if (head_due) begin
                  ctl.pop       = 1'b1;
                  rsp_kind_in   = KIND_FIRED;
                  rsp_handle_in = HANDLE_W'(cell_handle[0]);
                  rsp_sleep_in  = '0;
                  rsp_last_in   = 1'b0;
               end else begin
                  rsp_kind_in   = KIND_SLEEP;
                  rsp_handle_in = '0;
                  rsp_sleep_in  = sleep_value;
                  rsp_last_in   = 1'b1;
               end
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         poll_cap_ff  <= RESET_POLL_CAP;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            poll_cap_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_sleep_ff  <= rsp_sleep_in;
      rsp_last_ff   <= rsp_last_in;
      if (req_accept) begin
         now_ff <= req_current_time;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_sleep_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // occupied cells always form an unbroken run from the head
   a_row_packed: assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + CAPACITY'(1))) == '0)
      else $error("timer row has a gap");

   // a schedule request answers with a single final response next cycle
   a_sched_single: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_operation == OP_SCHEDULE |=> rsp_valid_ff && rsp_last_ff)
      else $error("schedule response missing");

   // a rejected or immediate schedule leaves the row untouched
   a_row_kept: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_operation == OP_SCHEDULE && (due_now || row_full)
      |=> $stable(cell_valid))
      else $error("row changed on a refused schedule");

   // fired responses of a tick never close it
   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_FIRED |-> !rsp_last_ff)
      else $error("fired response marked last");

endmodule

>>> tb/sorted_deadline_timer_queue_check.sv
// response checker for the sorted deadline timer queue: own timer table, expected response queue
module sorted_deadline_timer_queue_check import sdtq_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // deadline[63:0], handle[79:64], current_time[143:80]
   input  logic [143:0] req_tdata,
   // operation[0]
   input  logic [0:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fired_handle[15:0], sleep_interval[47:16]
   input  logic [47:0]  rsp_tdata,
   // kind[2:0]
   input  logic [2:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   output int           error_count,
   output int           pending_count,
   output int           response_count,
   output int           fired_count,
   output int           rejected_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
      logic [SLEEP_W-1:0]  sleep;
      logic                last;
   } response_type;

   // mirror of the timer table, earliest deadline at index 0
   logic [TIME_W-1:0]   deadline_row [CAPACITY];
   logic [HANDLE_W-1:0] handle_row [CAPACITY];
   int                  entries;
   logic [SLEEP_W-1:0]  poll_cap;
   response_type        awaited_responses [$];

   initial begin
      error_count = 0;
      pending_count = 0;
      response_count = 0;
      fired_count = 0;
      rejected_count = 0;
      entries = 0;
      poll_cap = RESET_POLL_CAP;
   end

   task automatic await_response(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] handle,
                                 logic [SLEEP_W-1:0] sleep, logic last);
      response_type r;
      r.kind = kind;
      r.handle = handle;
      r.sleep = sleep;
      r.last = last;
      awaited_responses.push_back(r);
   endtask

   // apply one request to the table and queue the responses it causes
   task automatic apply_timer_request(logic op, logic [TIME_W-1:0] deadline,
                                      logic [HANDLE_W-1:0] handle, logic [TIME_W-1:0] now);
      int slot;
      int i;
      logic [TIME_W-1:0] gap;
      logic [SLEEP_W-1:0] sleep;
      if (op == OP_SCHEDULE) begin
         if (deadline <= now) begin
            await_response(KIND_FIRED_NOW, handle, '0, 1'b1);
         end else if (entries >= CAPACITY) begin
            await_response(KIND_REJECTED, '0, '0, 1'b1);
         end else begin
            // insert behind every entry due at or before the new deadline
            slot = 0;
            while (slot < entries && deadline_row[slot] <= deadline) slot++;
            for (i = entries; i > slot; i--) begin
               deadline_row[i] = deadline_row[i-1];
               handle_row[i] = handle_row[i-1];
            end
            deadline_row[slot] = deadline;
            handle_row[slot] = handle;
            entries++;
            await_response(KIND_ACCEPTED, '0, '0, 1'b1);
         end
      end else begin
         // pop expired timers from the head, time held fixed for the tick
         while (entries > 0 && deadline_row[0] <= now) begin
            await_response(KIND_FIRED, handle_row[0], '0, 1'b0);
            for (i = 1; i < entries; i++) begin
               deadline_row[i-1] = deadline_row[i];
               handle_row[i-1] = handle_row[i];
            end
            entries--;
         end
         sleep = poll_cap;
         if (entries > 0) begin
            gap = deadline_row[0] - now;
            if (gap < {32'd0, poll_cap}) sleep = gap[SLEEP_W-1:0];
         end
         await_response(KIND_SLEEP, '0, sleep, 1'b1);
      end
   endtask

   // compare one response with the oldest expectation
   task automatic check_response();
      response_type want;
      response_count++;
      if (awaited_responses.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("unexpected response: kind %0d handle %h sleep %0d last %0b",
                     rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16], rsp_tlast);
      end else begin
         want = awaited_responses.pop_front();
         if (want.kind == KIND_FIRED) fired_count++;
         if (want.kind == KIND_REJECTED) rejected_count++;
         if (rsp_tuser !== want.kind || rsp_tdata[15:0] !== want.handle ||
             rsp_tdata[47:16] !== want.sleep || rsp_tlast !== want.last) begin
            error_count++;
            if (error_count <= 10)
               $display("response mismatch: expected kind %0d handle %h sleep %0d last %0b, %s",
                        want.kind, want.handle, want.sleep, want.last, "see actual below");
            if (error_count <= 10)
               $display("   actual kind %0d handle %h sleep %0d last %0b",
                        rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16], rsp_tlast);
         end
      end
   endtask

   // watch both channels and the register port at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         entries = 0;
         poll_cap = RESET_POLL_CAP;
         awaited_responses.delete();
      end else begin
         if (csr_wr_en) poll_cap = csr_wr_data;
         if (req_tvalid && req_tready)
            apply_timer_request(req_tuser[0], req_tdata[63:0], req_tdata[79:64],
                                req_tdata[143:80]);
         if (rsp_tvalid && rsp_tready) check_response();
      end
      pending_count = awaited_responses.size();
   end

endmodule

>>> tb/sorted_deadline_timer_queue_test.sv
// testbench top: stimulus, receiver pacing and verdict for the sorted deadline timer queue
module sorted_deadline_timer_queue_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sdtq_pkg::*;

   localparam int CAPACITY = 16;
   localparam int LIMIT_CYCLES = 300000;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEMS_PER_SETTING = 21;
   localparam int TAIL_CYCLES = 40;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wr_en = 1'b0;
   logic [31:0]  csr_wr_data = '0;

   int error_count;
   int pending_count;
   int response_count;
   int fired_count;
   int rejected_count;

   int send_idle_pct = 33;
   int recv_idle_pct = 64;
   int hold_left = 0;
   int cycle_count = 0;
   int requests_sent = 0;
   int ticks_sent = 0;
   logic [TIME_W-1:0] sim_now = 64'd5000;

   sorted_deadline_timer_queue #(
      .CAPACITY    (CAPACITY),
      .HANDLE_BITS (HANDLE_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   sorted_deadline_timer_queue_check #(
      .CAPACITY (CAPACITY)
   ) queue_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .response_count (response_count),
      .fired_count    (fired_count),
      .rejected_count (rejected_count)
   );

   // 100 MHz clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("sorted_deadline_timer_queue verification failed");
         $finish;
      end
   end

   // response side pacing, with a counted hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // offer one request and wait until it is taken
   task automatic send_request(logic op, logic [TIME_W-1:0] deadline,
                               logic [HANDLE_W-1:0] handle, logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {now, handle, deadline};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
      if (op == OP_TICK) ticks_sent++;
   endtask

   // poll cap changes only once every response is back
   task automatic drain_and_set_cap(logic [SLEEP_W-1:0] cap);
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = cap;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [SLEEP_W-1:0] cap_for_setting(int setting);
      case (setting)
         0: cap_for_setting = '0;
         1: cap_for_setting = '1;
         2: cap_for_setting = $urandom_range(1, 3000);
         3: cap_for_setting = $urandom;
         4: cap_for_setting = $urandom_range(200, 1200);
         default: cap_for_setting = RESET_POLL_CAP;
      endcase
   endfunction

   // mostly a moving timeline of near deadlines, some due ones and some noise
   task automatic random_request();
      int pick;
      logic [TIME_W-1:0] back;
      pick = $urandom_range(99);
      if (pick < 55) begin
         send_request(OP_SCHEDULE, sim_now + $urandom_range(1, 4000), 16'($urandom), sim_now);
      end else if (pick < 62) begin
         back = 64'($urandom_range(0, 40));
         send_request(OP_SCHEDULE, sim_now - back, 16'($urandom), sim_now);
      end else if (pick < 92) begin
         sim_now = sim_now + $urandom_range(0, 600);
         send_request(OP_TICK, {$urandom, $urandom}, 16'($urandom), sim_now);
      end else if (pick < 96) begin
         send_request(OP_SCHEDULE, {$urandom, $urandom}, 16'($urandom), sim_now);
      end else begin
         send_request(OP_TICK, {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
      end
   endtask

   // stimulus and verdict
   initial begin
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed: empty tick, due and far deadlines, equal deadlines, full table
      send_request(OP_TICK, '0, '0, '0);
      send_request(OP_SCHEDULE, '0, 16'hFFFF, '0);
      send_request(OP_SCHEDULE, TIME_MAX, 16'h0000, '0);
      send_request(OP_SCHEDULE, 64'd100, 16'h0001, '0);
      send_request(OP_SCHEDULE, 64'd100, 16'h0002, '0);
      send_request(OP_TICK, '0, '0, 64'd50);
      send_request(OP_TICK, '0, '0, 64'd100);
      for (int i = 0; i < CAPACITY - 1; i++)
         send_request(OP_SCHEDULE, 64'd1000 + i / 4, 16'(16'h1000 + i), 64'd10);
      send_request(OP_SCHEDULE, 64'd500, 16'h5555, 64'd10);
      send_request(OP_SCHEDULE, 64'd5, 16'hA5A5, 64'd10);
      send_request(OP_TICK, '0, '0, TIME_MAX);

      // random phases under three idling mixes and six poll cap settings
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 33 : (mode == 1) ? 64 : 0;
         recv_idle_pct = (mode == 0) ? 64 : (mode == 1) ? 33 : 0;
         for (int sub = 0; sub < 2; sub++) begin
            drain_and_set_cap(cap_for_setting(mode * 2 + sub));
            if (mode == 2 && sub == 0) hold_left = HOLD_CYCLES;
            repeat (ITEMS_PER_SETTING) random_request();
         end
      end

      // let every response come back
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("run covered %0d requests (%0d ticks), six poll caps, three idling mixes",
               requests_sent, ticks_sent);
      $display("%0d responses checked, %0d fired by ticks, %0d turned away when full",
               response_count, fired_count, rejected_count);
      if (error_count == 0) begin
         $display("sorted_deadline_timer_queue verification clean");
      end else begin
         $display("sorted_deadline_timer_queue verification failed");
      end
      $finish;
   end

endmodule
